>>> sv/suse_pkg.sv
// Shared types and codes for the sorted unique set engine.
// Request and response transaction layouts, action and status codes,
// and the controller-to-datapath command bundle. No dependencies.
package suse_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int VALUE_W  = 32;
    localparam int ACTION_W = 2;
    localparam int RANK_W   = 4;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISS  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FOUND = 3'd4;

    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic signed [VALUE_W-1:0] value;
        logic [RANK_W-1:0]         rank;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] read_value;
        logic [COUNT_W-1:0]        count;
    } t_rsp;

    // Controller commands to the datapath.
    typedef struct packed {
        logic load;     // capture the accepted request
        logic compare;  // evaluate every cell against the request value
        logic commit;   // apply the update and load the response register
    } t_cmd;

endpackage

>>> sv/sorted_unique_set_engine_top.sv
// Sorted unique set engine: keeps up to CAPACITY distinct signed 32-bit
// values in ascending order and answers insert, delete, search and
// read-at-rank requests. Every request returns exactly one response.
//
// Request channel: i_req_valid / o_req_stall / i_req (suse_pkg::t_req).
// Response channel: o_rsp_valid / i_rsp_stall / o_rsp (suse_pkg::t_rsp).
// A transaction moves on a clock edge with valid high and stall low.
//
// The controller walks accept, compare (every cell against the value in
// parallel) and commit (shift the cell row and load the response register)
// for each request, and stalls the request channel until commit; the
// response is registered and appears once commit has loaded it.
// A new request is taken while an earlier response still waits; its
// commit holds while the response register is full and stalled.
// Reset (synchronous, active low) empties the set; cell contents are
// left as they are and are never read above the count.
module sorted_unique_set_engine_top #(
    parameter int CAPACITY = suse_pkg::CAPACITY_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_stall,
    input  suse_pkg::t_req i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_stall,
    output suse_pkg::t_rsp o_rsp
);
    import suse_pkg::*;

    t_cmd w_cmd;

    suse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_cmd       (w_cmd)
    );

    suse_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

>>> sv/suse_ctrl.sv
// Controller for the sorted unique set engine: accept, compare, commit.
// Owns the input stall and the response valid register. Uses suse_pkg.
module suse_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_stall,
    output logic            o_rsp_valid,
    input  logic            i_rsp_stall,
    output suse_pkg::t_cmd  o_cmd
);
    import suse_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_rsp_valid;
    logic   n_rsp_valid;
    t_cmd   w_cmd;

    always_comb begin
        w_cmd         = '0;
        w_cmd.load    = (r_state == S_IDLE) && i_req_valid;
        w_cmd.compare = (r_state == S_CMP);
        // hold the update until the response register is free or draining
        w_cmd.commit  = (r_state == S_UPD) && (!r_rsp_valid || !i_rsp_stall);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (w_cmd.commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_rsp_valid = r_rsp_valid;
        if (w_cmd.commit) begin
            n_rsp_valid = 1'b1;
        end else if (r_rsp_valid && !i_rsp_stall) begin
            n_rsp_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_cmd       = w_cmd;

endmodule

>>> sv/suse_dp.sv
// Datapath for the sorted unique set engine: a row of compare-and-shift
// cells, the entry count, the request register and the response register.
// Uses suse_pkg; driven by suse_ctrl commands.
module suse_dp #(
    parameter int CAPACITY = suse_pkg::CAPACITY_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  suse_pkg::t_cmd  i_cmd,
    input  suse_pkg::t_req  i_req,
    output suse_pkg::t_rsp  o_rsp
);
    import suse_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [VALUE_W-1:0] r_entry [CAPACITY];
    logic signed [VALUE_W-1:0] n_entry [CAPACITY];
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    t_req                      r_req;
    t_rsp                      r_rsp;
    t_rsp                      n_rsp;
    logic [CAPACITY-1:0]       r_lt;
    logic [CAPACITY-1:0]       r_eq;

    logic signed [VALUE_W-1:0] w_below [CAPACITY];
    logic signed [VALUE_W-1:0] w_above [CAPACITY];
    logic [CAPACITY-1:0]       w_lt_below;
    logic [31:0]               w_count_ext;

    // Neighbor taps for each cell: insert pulls from below, delete from above.
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign w_below[g]    = $signed(r_req.value);
                assign w_lt_below[g] = 1'b1;
            end else begin : g_mid
                assign w_below[g]    = r_entry[g-1];
                assign w_lt_below[g] = r_lt[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_above[g] = r_entry[g];
            end else begin : g_inner
                assign w_above[g] = r_entry[g+1];
            end
        end
    endgenerate

    always_comb begin
        logic                      hit;
        logic                      full;
        logic                      do_ins;
        logic                      do_del;
        logic                      rank_hit;
        logic signed [VALUE_W-1:0] rd;

        hit      = |r_eq;
        full     = (r_count >= CW'(CAPACITY));
        do_ins   = (r_req.action == ACT_INSERT) && !hit && !full;
        do_del   = (r_req.action == ACT_DELETE) && hit;
        rank_hit = 1'b0;
        rd       = '0;

        for (int i = 0; i < CAPACITY; i++) begin
            if ((i < 16) && (r_req.rank == RANK_W'(i)) && (i < int'(r_count))) begin
                rank_hit = 1'b1;
                rd       = r_entry[i];
            end
        end

        for (int i = 0; i < CAPACITY; i++) begin
            n_entry[i] = r_entry[i];
            if (do_ins && !r_lt[i]) begin
                n_entry[i] = w_lt_below[i] ? $signed(r_req.value) : w_below[i];
            end else if (do_del && !r_lt[i]) begin
                n_entry[i] = w_above[i];
            end
        end

        n_count = r_count;
        if (do_ins) begin
            n_count = r_count + CW'(1);
        end else if (do_del) begin
            n_count = r_count - CW'(1);
        end

        n_rsp            = '0;
        n_rsp.status     = ST_DONE;
        n_rsp.read_value = '0;
        case (r_req.action)
            ACT_INSERT: begin
                if (hit) begin
                    n_rsp.status = ST_DUP;
                end else if (full) begin
                    n_rsp.status = ST_FULL;
                end
            end
            ACT_DELETE: begin
                if (!hit) begin
                    n_rsp.status = ST_MISS;
                end
            end
            ACT_SEARCH: begin
                n_rsp.status = hit ? ST_FOUND : ST_MISS;
            end
            ACT_READ: begin
                if (rank_hit) begin
                    n_rsp.read_value = rd;
                end else begin
                    n_rsp.status = ST_MISS;
                end
            end
            default: begin
                n_rsp.status = ST_MISS;
            end
        endcase
        n_rsp.count = w_count_ext[COUNT_W-1:0];
    end

    // Count field is the low bits of the post-update count.
    assign w_count_ext = 32'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.compare) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_lt[i] <= (i < int'(r_count)) && (r_entry[i] < $signed(r_req.value));
                r_eq[i] <= (i < int'(r_count)) && (r_entry[i] == $signed(r_req.value));
            end
        end
        if (i_cmd.commit) begin
            r_entry <= n_entry;
            r_rsp   <= n_rsp;
        end
    end

    assign o_rsp = r_rsp;

endmodule
